>>> hw/rtl/tefc_pkg.sv
// ----------------------------------------------------------------------------
// tefc_pkg: shared types and constants of the transfer-efficiency FOD check
// Field widths, codes, register map, queue item and divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package tefc_pkg;

   // Field widths
   localparam int unsigned ADC_W      = 12;
   localparam int unsigned RXP_W      = 16;
   localparam int unsigned MAXP_W     = 8;
   localparam int unsigned THR_W      = 10;
   localparam int unsigned EFF_W      = 23;
   localparam int unsigned FCNT_W     = 2;
   localparam int unsigned SCALED_W   = 16;
   localparam int unsigned DELTA_W    = 14;
   localparam int unsigned NUM_W      = 23;
   localparam int unsigned DEN_W      = 28;
   localparam int unsigned PROD_W     = SCALED_W + DELTA_W - 1;
   localparam int unsigned DIV_STEPS  = NUM_W;
   localparam int unsigned STEP_W     = $clog2(DIV_STEPS + 1);

   // Arithmetic constants
   localparam logic [RXP_W-1:0]   RX_FLOOR       = 16'd1280;
   localparam logic [DELTA_W-1:0] NO_LOAD_COUNTS = 14'd5;
   localparam logic [3:0]         VOLT_SCALE     = 4'd10;
   localparam logic [6:0]         PERCENT        = 7'd100;

   // Register reset values
   localparam logic [MAXP_W-1:0] PWR_UNITS_RST    = 8'd30;
   localparam logic [ADC_W-1:0]  CUR_OFFSET_RST   = 12'd0;
   localparam logic [THR_W-1:0]  EFF_THRESH_RST   = 10'd65;
   localparam logic [ADC_W-1:0]  OC_LIMIT_RST     = 12'd4000;

   // Parameter defaults
   localparam int unsigned FAIL_LIMIT_DEF  = 3;
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   typedef enum logic [1:0] {
      REG_PWR_UNITS      = 2'd0,
      REG_CURRENT_OFFSET = 2'd1,
      REG_EFF_THRESHOLD  = 2'd2,
      REG_OC_LIMIT       = 2'd3
   } reg_index_type;

   typedef enum logic {
      ACT_EVAL  = 1'b0,
      ACT_CLEAR = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      CAUSE_OK           = 2'd0,
      CAUSE_OC_TRIP      = 2'd1,
      CAUSE_CONFIRMED    = 2'd2,
      CAUSE_PENDING      = 2'd3
   } cause_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV1 = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_DIV2 = 4'b1000
   } back_state_type;

   // Classified measurement, as queued between front and back
   typedef struct packed {
      action_type          action;
      logic                oc_trip;
      logic [MAXP_W-1:0]   divisor;
      logic [SCALED_W-1:0] volt_scaled;
      logic [DELTA_W-1:0]  delta;
      logic [NUM_W-1:0]    numerator;
   } item_type;

   typedef struct packed {
      logic [FCNT_W-1:0] failure_count;
      logic [EFF_W-1:0]  efficiency_value;
      cause_type         cause;
      logic              trip;
   } result_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/tefc_front.sv
// ----------------------------------------------------------------------------
// tefc_front: measurement intake and classification
// Takes request transfers, flags over-current and precomputes the operands
// of the first division and the dividend of the second before handing the item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tefc_front
   import tefc_pkg::*;
(
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [39:0]         req_tdata,
   input  wire logic                req_tuser,
   input  wire logic [MAXP_W-1:0]   pwr_units,
   input  wire logic [ADC_W-1:0]    current_offset,
   input  wire logic [ADC_W-1:0]    oc_limit,
   input  wire logic                queue_full,
   output logic                     push,
   output item_type                 push_item
);

   logic [ADC_W-1:0] current_counts;
   logic [ADC_W-1:0] voltage_counts;
   logic [RXP_W-1:0] received_power;
   logic [RXP_W-1:0] rx_floored;

   assign current_counts = req_tdata[11:0];
   assign voltage_counts = req_tdata[23:12];
   assign received_power = req_tdata[39:24];

   assign req_tready = ~queue_full;
   assign push       = req_tvalid & ~queue_full;

   assign rx_floored = (received_power < RX_FLOOR) ? RX_FLOOR : received_power;

   always_comb begin
      push_item.action       = action_type'(req_tuser);
      push_item.oc_trip      = current_counts > oc_limit;
      // a zero divisor acts as one
      push_item.divisor      = (pwr_units == '0) ? MAXP_W'(1) : pwr_units;
      push_item.volt_scaled  = SCALED_W'(voltage_counts) * SCALED_W'(VOLT_SCALE);
      push_item.delta        = DELTA_W'(current_counts) - DELTA_W'(current_offset)
                               - NO_LOAD_COUNTS;
      push_item.numerator    = NUM_W'(rx_floored) * NUM_W'(PERCENT);
   end

endmodule

`default_nettype wire

>>> hw/rtl/tefc_queue.sv
// ----------------------------------------------------------------------------
// tefc_queue: short item queue between front and back
// Register-based FIFO so intake and evaluation stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module tefc_queue
   import tefc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   input  wire logic pop,
   output item_type  head_item,
   output logic      full,
   output logic      empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign empty     = count_ff == '0;
   assign head_item = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
      end
      if (pop) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/tefc_div.sv
// ----------------------------------------------------------------------------
// tefc_div: shared restoring divider
// One quotient bit per cycle, MSB first; done pulses after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module tefc_div
   import tefc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    shifted;
   logic [DEN_W+1:0]  diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = ~diff[DEN_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         // remainder stays below the divisor, so it fits DEN_W bits
         rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
         step_in = STEP_W'(DIV_STEPS);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/tefc_back.sv
// ----------------------------------------------------------------------------
// tefc_back: evaluation sequencer
// Runs voltage scaling, transmit power product and efficiency division, then
// updates the failure counter and the result register; a clear zeroes both.
// ----------------------------------------------------------------------------
`default_nettype none

module tefc_back
   import tefc_pkg::*;
#(
   parameter int unsigned FAIL_LIMIT = FAIL_LIMIT_DEF
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [THR_W-1:0]   eff_limit,
   input  item_type                head_item,
   input  wire logic               queue_empty,
   output logic                    pop,
   output div_req_type             div_req,
   input  div_rsp_type             div_rsp,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output result_type              rsp_result
);

   back_state_type      state_ff, state_in;
   item_type            item_ff, item_in;
   logic [SCALED_W-1:0] scaled_ff, scaled_in;
   logic [FCNT_W-1:0]   fail_cnt_ff, fail_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff, rsp_data_in;

   logic [PROD_W-1:0]   tx_prod;
   logic [DEN_W-1:0]    tx_power;
   logic                delta_le_zero;
   logic [EFF_W-1:0]    eff;
   logic [FCNT_W-1:0]   fail_next;

   assign tx_prod       = PROD_W'(scaled_ff) * PROD_W'(item_ff.delta[DELTA_W-2:0]);
   assign delta_le_zero = item_ff.delta[DELTA_W-1] | (item_ff.delta == '0);
   // clamp the transmit estimate to at least one
   assign tx_power      = (delta_le_zero || scaled_ff == '0) ? DEN_W'(1)
                                                             : tx_prod[DEN_W-1:0];
   assign eff           = (div_rsp.quotient == '0) ? EFF_W'(1) : div_rsp.quotient;
   assign fail_next     = fail_cnt_ff + FCNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      scaled_in    = scaled_ff;
      fail_cnt_in  = fail_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty && !rsp_valid_ff) begin
               pop     = 1'b1;
               item_in = head_item;
               if (head_item.action == ACT_CLEAR) begin
                  fail_cnt_in  = '0;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = NUM_W'(head_item.volt_scaled);
                  div_req.divisor  = DEN_W'(head_item.divisor);
                  state_in         = ST_DIV1;
               end
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               scaled_in = div_rsp.quotient[SCALED_W-1:0];
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            div_req.start    = 1'b1;
            div_req.dividend = item_ff.numerator;
            div_req.divisor  = tx_power;
            state_in         = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               rsp_data_in.efficiency_value = eff;
               rsp_data_in.trip             = 1'b0;
               rsp_data_in.cause            = CAUSE_OK;
               if (item_ff.oc_trip) begin
                  fail_cnt_in       = '0;
                  rsp_data_in.trip  = 1'b1;
                  rsp_data_in.cause = CAUSE_OC_TRIP;
               end else if (eff < EFF_W'(eff_limit)) begin
                  if (fail_next >= FCNT_W'(FAIL_LIMIT)) begin
                     fail_cnt_in       = '0;
                     rsp_data_in.trip  = 1'b1;
                     rsp_data_in.cause = CAUSE_CONFIRMED;
                  end else begin
                     fail_cnt_in       = fail_next;
                     rsp_data_in.cause = CAUSE_PENDING;
                  end
               end else begin
                  fail_cnt_in = '0;
               end
               rsp_data_in.failure_count = fail_cnt_in;
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fail_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fail_cnt_ff  <= fail_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      scaled_ff   <= scaled_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/transfer_efficiency_fod_check.sv
// An evaluation takes two restoring-divider passes of 23 steps each plus
// sequencing after it leaves the queue; a clear action is answered from the
// result register once it leaves the queue. Evaluations run one at a time,
// bounded by the shared divider; the queue keeps taking requests while a
// result waits, until it is full. Reset (synchronous) restores register
// defaults and clears the failure counter, queue and result valid flag.
// ----------------------------------------------------------------------------
// transfer_efficiency_fod_check: wireless charger foreign-object check
// Estimates transmit power, forms transfer efficiency and trips on
// over-current or on repeated low efficiency.
// ----------------------------------------------------------------------------
`default_nettype none

module transfer_efficiency_fod_check
   import tefc_pkg::*;
#(
   parameter int unsigned FAIL_LIMIT  = FAIL_LIMIT_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [11:0] current_counts, [23:12] voltage_counts, [39:24] received_power
   input  wire logic [39:0] req_tdata,
   // [0] action
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] trip, [2:1] cause, [25:3] efficiency_value, [27:26] failure_count
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [MAXP_W-1:0] pwr_units_ff;
   logic [ADC_W-1:0]  cur_offset_ff;
   logic [THR_W-1:0]  eff_thresh_ff;
   logic [ADC_W-1:0]  oc_limit_ff;
   reg_index_type     reg_sel;
   logic              csr_write;

   logic        push;
   item_type    push_item;
   item_type    head_item;
   logic        queue_full;
   logic        queue_empty;
   logic        pop;
   div_req_type div_req;
   div_rsp_type div_rsp;
   result_type  rsp_result;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwr_units_ff    <= PWR_UNITS_RST;
         cur_offset_ff   <= CUR_OFFSET_RST;
         eff_thresh_ff   <= EFF_THRESH_RST;
         oc_limit_ff     <= OC_LIMIT_RST;
      end else if (csr_write) begin
         case (reg_sel)
            REG_PWR_UNITS:      pwr_units_ff    <= csr_pwdata[MAXP_W-1:0];
            REG_CURRENT_OFFSET: cur_offset_ff   <= csr_pwdata[ADC_W-1:0];
            REG_EFF_THRESHOLD:  eff_thresh_ff   <= csr_pwdata[THR_W-1:0];
            REG_OC_LIMIT:       oc_limit_ff     <= csr_pwdata[ADC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PWR_UNITS:      csr_prdata = 32'(pwr_units_ff);
         REG_CURRENT_OFFSET: csr_prdata = 32'(cur_offset_ff);
         REG_EFF_THRESHOLD:  csr_prdata = 32'(eff_thresh_ff);
         REG_OC_LIMIT:       csr_prdata = 32'(oc_limit_ff);
         default:            csr_prdata = '0;
      endcase
   end

   tefc_front u_front (
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .pwr_units          (pwr_units_ff),
      .current_offset     (cur_offset_ff),
      .oc_limit           (oc_limit_ff),
      .queue_full         (queue_full),
      .push               (push),
      .push_item          (push_item)
   );

   tefc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   tefc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tefc_back #(
      .FAIL_LIMIT (FAIL_LIMIT)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .eff_limit            (eff_thresh_ff),
      .head_item            (head_item),
      .queue_empty          (queue_empty),
      .pop                  (pop),
      .div_req              (div_req),
      .div_rsp              (div_rsp),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_result           (rsp_result)
   );

   assign rsp_tdata = 32'(rsp_result);

endmodule

`default_nettype wire

>>> hw/rtl/tefc_checker.sv
// ----------------------------------------------------------------------------
// tefc_checker: port-level checks of the FOD check result channel
// Watches the result stream for consistency between trip, cause and count.
// ----------------------------------------------------------------------------
`default_nettype none

module tefc_checker
   import tefc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // trip only with over current or confirmed failures
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsp_tdata[2:1] == CAUSE_OC_TRIP ||
                                      rsp_tdata[2:1] == CAUSE_CONFIRMED))
      else $error("trip does not match cause");

   // a trip always leaves the failure counter cleared
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[27:26] == '0)
      else $error("failure count kept after trip");

   // a pending failure is counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:1] == CAUSE_PENDING |->
         rsp_tdata[27:26] != '0 && rsp_tdata[25:3] != '0)
      else $error("pending cause without count");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind transfer_efficiency_fod_check tefc_checker u_tefc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for transfer_efficiency_fod_check
// Streams measurements and clear actions through the request channel. A
// scoreboard predicts trip, cause, efficiency and failure count for each
// transfer and checks every result in order. Register settings change
// between phases over the APB port and are read back.
// ----------------------------------------------------------------------------

import tefc_pkg::*;

typedef struct {
   action_type  act;
   logic [11:0] cur;
   logic [11:0] volt;
   logic [15:0] rx;
} measurement_type;

class fod_scoreboard;
   localparam int RX_MIN        = 1280;
   localparam int IDLE_COUNTS   = 5;
   localparam int VOLT_GAIN     = 10;
   localparam int PCT           = 100;
   localparam int CONFIRM_LIMIT = 3;
   localparam int PRINT_CAP     = 40;

   logic [7:0]  pwr_units;
   logic [11:0] offset;
   logic [9:0]  threshold;
   logic [11:0] oc_limit;
   int          low_run;
   result_type  expected_status[$];
   int          mismatches;
   int          checked;
   int          cause_seen[4];

   function new();
      pwr_units = 8'd30;
      offset    = 12'd0;
      threshold = 10'd65;
      oc_limit  = 12'd4000;
      low_run   = 0;
   endfunction

   function void set_register(reg_index_type idx, logic [31:0] value);
      case (idx)
         REG_PWR_UNITS:      pwr_units = value[7:0];
         REG_CURRENT_OFFSET: offset    = value[11:0];
         REG_EFF_THRESHOLD:  threshold = value[9:0];
         REG_OC_LIMIT:       oc_limit  = value[11:0];
         default: ;
      endcase
   endfunction

   function result_type evaluate_measurement(measurement_type m);
      result_type r;
      longint     rx_used, divisor, scaled, delta, tx, eff;
      r = '0;
      if (m.act == ACT_CLEAR) begin
         low_run = 0;
         r.cause = CAUSE_OK;
         return r;
      end
      rx_used = (m.rx < RX_MIN) ? RX_MIN : longint'(m.rx);
      divisor = (pwr_units == 0) ? 1 : longint'(pwr_units);
      scaled  = (longint'(m.volt) * VOLT_GAIN) / divisor;
      delta   = longint'(m.cur) - longint'(offset) - IDLE_COUNTS;
      tx      = scaled * delta;
      if (tx < 1) tx = 1;
      eff = (rx_used * PCT) / tx;
      if (eff < 1) eff = 1;
      if (m.cur > oc_limit) begin
         low_run = 0;
         r.trip  = 1'b1;
         r.cause = CAUSE_OC_TRIP;
      end else if (eff < longint'(threshold)) begin
         low_run = (low_run + 1) & 3;
         if (low_run >= CONFIRM_LIMIT) begin
            low_run = 0;
            r.trip  = 1'b1;
            r.cause = CAUSE_CONFIRMED;
         end else begin
            r.cause = CAUSE_PENDING;
         end
      end else begin
         low_run = 0;
         r.cause = CAUSE_OK;
      end
      r.efficiency_value = eff[22:0];
      r.failure_count    = low_run[1:0];
      return r;
   endfunction

   function void note_request(measurement_type m);
      expected_status.push_back(evaluate_measurement(m));
   endfunction

   task report(string msg);
      if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
   endtask

   task check_result(logic [31:0] data);
      result_type got, want;
      got = result_type'(data[27:0]);
      if (expected_status.size() == 0) begin
         report($sformatf("result %h with nothing outstanding", data));
         return;
      end
      want = expected_status.pop_front();
      checked++;
      cause_seen[want.cause]++;
      if (got.trip !== want.trip)
         report($sformatf("trip %0b, want %0b", got.trip, want.trip));
      if (got.cause !== want.cause)
         report($sformatf("cause %0d, want %0d", got.cause, want.cause));
      if (got.efficiency_value !== want.efficiency_value)
         report($sformatf("efficiency %0d, want %0d",
                          got.efficiency_value, want.efficiency_value));
      if (got.failure_count !== want.failure_count)
         report($sformatf("failure count %0d, want %0d",
                          got.failure_count, want.failure_count));
      if (data[31:28] !== 4'd0)
         report($sformatf("padding bits %h not zero", data[31:28]));
   endtask
endclass

module tb_top;
   localparam int STALL_LIMIT   = 4000;
   localparam int LONG_HOLD     = 400;
   localparam int TAIL_CYCLES   = 60;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 255;
   localparam int REG_WIDTH [4] = '{8, 12, 10, 12};

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // [11:0] current_counts, [23:12] voltage_counts, [39:24] received_power
   logic [39:0] req_tdata   = '0;
   // [0] action
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // [0] trip, [2:1] cause, [25:3] efficiency_value, [27:26] failure_count
   logic [31:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fod_scoreboard sb;
   bit            gaps_on       = 1'b1;
   bit            hold_request  = 1'b0;
   int            idle_cycles   = 0;
   int            sent          = 0;

   transfer_efficiency_fod_check dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Watchdog: count cycles without any transfer on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("** transfer_efficiency_fod_check: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stalls per transfer, one long hold on request
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end
         stall = gaps_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_measurement(input measurement_type m);
      int gap;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {m.rx, m.volt, m.cur};
      req_tuser  <= m.act;
      do @(posedge clock); while (!req_tready);
      sb.note_request(m);
      sent++;
   endtask

   task automatic send_eval(input int cur, input int volt, input int rx);
      measurement_type m;
      m.act  = ACT_EVAL;
      m.cur  = cur[11:0];
      m.volt = volt[11:0];
      m.rx   = rx[15:0];
      send_measurement(m);
   endtask

   task automatic send_clear(input int cur, input int volt, input int rx);
      measurement_type m;
      m.act  = ACT_CLEAR;
      m.cur  = cur[11:0];
      m.volt = volt[11:0];
      m.rx   = rx[15:0];
      send_measurement(m);
   endtask

   // Drop valid, then wait until every outstanding result has arrived
   task automatic wait_drained();
      @(negedge clock) req_tvalid <= 1'b0;
      while (sb.expected_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input reg_index_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_settings(input int mp, input int off, input int thr, input int oc);
      logic [31:0] value [4];
      logic [31:0] mask, wdata, rdata;
      value = '{mp, off, thr, oc};
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         // junk above the field width must be dropped
         wdata = value[i] | ($urandom << REG_WIDTH[i]);
         csr_access(1'b1, reg_index_type'(i), wdata, rdata);
         sb.set_register(reg_index_type'(i), wdata);
      end
      for (int i = 0; i < 4; i++) begin
         mask = (32'd1 << REG_WIDTH[i]) - 32'd1;
         csr_access(1'b0, reg_index_type'(i), 32'd0, rdata);
         if (((rdata ^ value[i]) & mask) != 0)
            sb.report($sformatf("register %0d reads %h, want %h", i, rdata, value[i]));
      end
   endtask

   function automatic measurement_type next_measurement();
      measurement_type m;
      int pick, cur, hi, rsel;
      m.act = ($urandom_range(0, 99) < 8) ? ACT_CLEAR : ACT_EVAL;
      pick  = $urandom_range(0, 9);
      hi    = int'(sb.oc_limit);
      if (pick < 4) begin
         // near the zero-current point: high efficiency, breaks low runs
         cur = sb.offset + 5 + $urandom_range(0, 40);
         if (cur > 4095) cur = 4095;
      end else if (pick < 8) begin
         cur = $urandom_range(0, hi);
      end else if (pick == 8 && hi < 4095) begin
         cur = $urandom_range(hi + 1, 4095);
      end else begin
         cur = $urandom_range(0, 4095);
      end
      m.cur  = cur[11:0];
      m.volt = 12'($urandom_range(0, 4095));
      rsel   = $urandom_range(0, 3);
      if (rsel == 0)      m.rx = 16'($urandom_range(0, 1500));
      else if (rsel == 1) m.rx = 16'($urandom_range(60000, 65535));
      else                m.rx = 16'($urandom_range(0, 65535));
      return m;
   endfunction

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Reset settings: floors, saturation, over-current edge, confirm and clear
      send_eval(0, 0, 0);
      send_eval(4095, 4095, 65535);
      repeat (3) send_eval(4000, 4095, 0);
      repeat (2) send_eval(4000, 4095, 0);
      send_clear(4095, 4095, 65535);
      send_eval(4000, 4095, 0);
      send_eval(5, 4095, 1279);
      send_eval(2, 4095, 65535);
      send_eval(100, 2048, 1280);
      send_eval(100, 2048, 1281);
      send_eval(100, 2048, 65535);

      // Zero divisor, largest offset, threshold above range, zero limit
      apply_settings(0, 4095, 1023, 0);
      send_eval(0, 4095, 0);
      send_eval(1, 4095, 65535);
      send_clear(0, 0, 0);

      apply_settings(255, 0, 0, 4095);
      send_eval(4095, 4095, 65535);
      send_eval(4095, 0, 0);

      apply_settings(1, 0, 1000, 4095);
      send_eval(6, 1, 1280);
      repeat (3) send_eval(4095, 4095, 65535);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_settings(30, 0, 65, 4000);
            1: apply_settings(1, 0, 1023, 4095);
            2: apply_settings(255, $urandom_range(0, 50), $urandom_range(0, 100),
                              $urandom_range(2000, 4095));
            4: apply_settings($urandom_range(1, 255), 0, 1000, $urandom_range(0, 4095));
            default: apply_settings($urandom_range(0, 255), $urandom_range(0, 300),
                                    $urandom_range(0, 1023), $urandom_range(0, 4095));
         endcase
         gaps_on = (p != 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 30) hold_request = 1'b1;
            if (p == 3 && n == PHASE_ITEMS / 2) wait_drained();
            send_measurement(next_measurement());
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.expected_status.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.expected_status.size()));

      $display("Sent %0d requests over %0d register settings; checked %0d results.",
               sent, PHASES + 3, sb.checked);
      $display("Outcomes: %0d ok, %0d over-current, %0d confirmed, %0d pending.",
               sb.cause_seen[CAUSE_OK], sb.cause_seen[CAUSE_OC_TRIP],
               sb.cause_seen[CAUSE_CONFIRMED], sb.cause_seen[CAUSE_PENDING]);
      if (sb.mismatches == 0) begin
         $display("** transfer_efficiency_fod_check: PASSED **");
      end else begin
         $display("** transfer_efficiency_fod_check: FAILED **");
      end
      $finish;
   end
endmodule
